### rtl/sfd_pkg.sv
// Shared types and constants for the smoothed feedback delay.
// Holds register widths, reset values, register indexes and the config struct.
// No dependencies.
package sfd_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int STORE_DEPTH_DEF  = 131072;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // Register widths.
    localparam int TGT_DELAY_W  = 17;
    localparam int TGT_FB_W     = 15;
    localparam int TGT_MIX_W    = 16;
    localparam int COEFF_W      = 16;
    localparam int DELAY_FRAC_W = 8;

    // Configuration write port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MIX      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_COEFF = 2'd3;

    // Reset values.
    localparam int TGT_DELAY_RST = 24000;
    localparam int TGT_FB_RST    = 16384;
    localparam int TGT_MIX_RST   = 16384;
    localparam int COEFF_RST     = 66;

    // Unity gain in Q1.15.
    localparam int ONE_Q15 = 32768;

    typedef struct packed {
        logic [TGT_DELAY_W-1:0] target_delay;
        logic [TGT_FB_W-1:0]    target_feedback;
        logic [TGT_MIX_W-1:0]   target_mix;
        logic [COEFF_W-1:0]     smoothing_coeff;
    } t_cfg;

endpackage

### rtl/sfd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on sfd_pkg for its default sizes.
module sfd_ram
    import sfd_pkg::*;
#(
    parameter int WIDTH = SAMPLE_WIDTH_DEF,
    parameter int DEPTH = STORE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sfd_core.sv
// Sequencer and datapath of the smoothed feedback delay: control smoothing,
// delay-line addressing and the mix arithmetic on one shared multiplier.
// Depends on sfd_pkg; drives the ports of an sfd_ram instance.
module sfd_core
    import sfd_pkg::*;
#(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_res_ready,
    output logic                           o_res_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_res,
    output logic                           o_ram_we,
    output logic [AW-1:0]                  o_ram_waddr,
    output logic [SAMPLE_WIDTH-1:0]        o_ram_wdata,
    output logic [AW-1:0]                  o_ram_raddr,
    input  logic [SAMPLE_WIDTH-1:0]        i_ram_rdata
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SD_W  = TGT_DELAY_W + DELAY_FRAC_W;
    localparam int MA_W  = TGT_MIX_W + 2;
    localparam int MB_W  = (SD_W + 1 > SW + 2) ? SD_W + 1 : SW + 2;
    localparam int P_W   = MA_W + MB_W;
    localparam int TAP_W = SW + 2;
    localparam int CW    = (TGT_DELAY_W > AW) ? TGT_DELAY_W : AW;

    localparam logic signed [P_W-1:0] RND16  = P_W'(32768);
    localparam logic signed [P_W-1:0] RND15  = P_W'(16384);
    localparam logic signed [P_W:0]   RND15W = (P_W+1)'(16384);
    localparam logic signed [P_W:0]   SAT_HI = (P_W+1)'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [P_W:0]   SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DLY,
        ST_FB,
        ST_MIX,
        ST_TAP,
        ST_TAPR,
        ST_WET,
        ST_DRY,
        ST_OUT
    } t_state;

    t_state                  r_state;
    logic [SD_W-1:0]         r_sd;
    logic [TGT_FB_W-1:0]     r_sf;
    logic [TGT_MIX_W-1:0]    r_sm;
    logic [AW-1:0]           r_wp;
    logic                    r_full;
    logic signed [SW-1:0]    r_x;
    logic signed [P_W-1:0]   r_prod;
    logic signed [TAP_W-1:0] r_tap;
    logic signed [P_W-1:0]   r_acc;
    logic                    r_rd_ok;

    logic signed [SD_W:0]      dly_diff;
    logic signed [TGT_FB_W:0]  fb_diff;
    logic signed [TGT_MIX_W:0] mix_diff;
    logic [TGT_FB_W:0]         fb_gain;
    logic signed [TGT_MIX_W:0] dry_gain;
    logic signed [SW-1:0]      rdata_s;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [P_W-1:0]     mul_p;
    logic signed [P_W-1:0]     rnd16;
    logic signed [P_W-1:0]     rnd15;
    logic [SD_W-1:0]           n_sd;
    logic [TGT_FB_W-1:0]       n_sf;
    logic [TGT_MIX_W-1:0]      n_sm;
    logic signed [TAP_W-1:0]   n_tap;
    logic signed [P_W:0]       acc;
    logic signed [P_W:0]       y_pre;
    logic signed [SW-1:0]      n_y;
    logic [TGT_DELAY_W-1:0]    dly_whole;
    logic [AW-1:0]             dly_c;
    logic [AW:0]               rd_sum;
    logic [AW-1:0]             raddr;
    logic                      rd_ok_n;
    logic                      finish;

    // Differences toward the targets; the whole-sample delay target is widened to Q.8.
    assign dly_diff = $signed({1'b0, i_cfg.target_delay, {DELAY_FRAC_W{1'b0}}})
                    - $signed({1'b0, r_sd});
    assign fb_diff  = $signed({1'b0, i_cfg.target_feedback}) - $signed({1'b0, r_sf});
    assign mix_diff = $signed({1'b0, i_cfg.target_mix}) - $signed({1'b0, r_sm});

    assign fb_gain  = (TGT_FB_W+1)'(ONE_Q15) + (TGT_FB_W+1)'(r_sf);
    assign dry_gain = (TGT_MIX_W+1)'(ONE_Q15) - {1'b0, r_sm};
    assign rdata_s  = $signed(i_ram_rdata);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_DLY: begin
                mul_a = MA_W'({1'b0, i_cfg.smoothing_coeff});
                mul_b = MB_W'(dly_diff);
            end
            ST_FB: begin
                mul_a = MA_W'({1'b0, i_cfg.smoothing_coeff});
                mul_b = MB_W'(fb_diff);
            end
            ST_MIX: begin
                mul_a = MA_W'({1'b0, i_cfg.smoothing_coeff});
                mul_b = MB_W'(mix_diff);
            end
            ST_TAP: begin
                mul_a = MA_W'(fb_gain);
                // An entry never written since reset reads as silence.
                mul_b = r_rd_ok ? MB_W'(rdata_s) : '0;
            end
            ST_WET: begin
                mul_a = MA_W'({1'b0, r_sm});
                mul_b = MB_W'(r_tap);
            end
            ST_DRY: begin
                mul_a = MA_W'(dry_gain);
                mul_b = MB_W'(r_x);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round-half-up shifts of the registered product.
    assign rnd16 = (r_prod + RND16) >>> 16;
    assign rnd15 = (r_prod + RND15) >>> 15;
    assign n_sd  = r_sd + SD_W'(rnd16);
    assign n_sf  = r_sf + TGT_FB_W'(rnd16);
    assign n_sm  = r_sm + TGT_MIX_W'(rnd16);
    assign n_tap = TAP_W'(rnd15);

    // Final sum of wet and dry parts, rounded and saturated.
    assign acc   = (P_W+1)'(r_acc) + (P_W+1)'(r_prod);
    assign y_pre = (acc + RND15W) >>> 15;

    always_comb begin
        if (y_pre > SAT_HI) begin
            n_y = SW'(SAT_HI);
        end else if (y_pre < SAT_LO) begin
            n_y = SW'(SAT_LO);
        end else begin
            n_y = SW'(y_pre);
        end
    end

    // Read address: write position minus the clamped whole-sample delay.
    assign dly_whole = r_sd[SD_W-1:DELAY_FRAC_W];

    always_comb begin
        if (CW'(dly_whole) > CW'(STORE_DEPTH - 1)) begin
            dly_c = AW'(STORE_DEPTH - 1);
        end else begin
            dly_c = AW'(dly_whole);
        end
    end

    always_comb begin
        if (r_wp >= dly_c) begin
            rd_sum = {1'b0, r_wp} - {1'b0, dly_c};
        end else begin
            rd_sum = {1'b0, r_wp} + (AW+1)'(STORE_DEPTH) - {1'b0, dly_c};
        end
    end

    assign raddr = rd_sum[AW-1:0];

    // Entries are written in address order from zero, so a fill flag and
    // the write position tell which entries have not been written since reset.
    assign rd_ok_n = r_full || (raddr < r_wp);

    assign finish = (r_state == ST_OUT) && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sd    <= SD_W'(TGT_DELAY_RST) << DELAY_FRAC_W;
            r_sf    <= TGT_FB_W'(TGT_FB_RST);
            r_sm    <= TGT_MIX_W'(TGT_MIX_RST);
            r_wp    <= '0;
            r_full  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_DLY;
                    end
                end
                ST_DLY: begin
                    r_state <= ST_FB;
                end
                ST_FB: begin
                    r_sd    <= n_sd;
                    r_state <= ST_MIX;
                end
                ST_MIX: begin
                    r_sf    <= n_sf;
                    r_state <= ST_TAP;
                end
                ST_TAP: begin
                    r_sm    <= n_sm;
                    r_state <= ST_TAPR;
                end
                ST_TAPR: begin
                    r_state <= ST_WET;
                end
                ST_WET: begin
                    r_state <= ST_DRY;
                end
                ST_DRY: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_res_ready) begin
                        if (r_wp == AW'(STORE_DEPTH - 1)) begin
                            r_wp   <= '0;
                            r_full <= 1'b1;
                        end else begin
                            r_wp <= r_wp + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state) inside
            ST_IDLE: begin
                r_x <= i_sample;
            end
            ST_MIX: begin
                r_rd_ok <= rd_ok_n;
                r_prod  <= mul_p;
            end
            ST_TAPR: begin
                r_tap <= n_tap;
            end
            ST_DRY: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            ST_DLY, ST_FB, ST_TAP, ST_WET: begin
                r_prod <= mul_p;
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = finish;
    assign o_res       = n_y;
    assign o_ram_we    = finish;
    assign o_ram_waddr = r_wp;
    assign o_ram_wdata = n_y;
    assign o_ram_raddr = raddr;

endmodule

### rtl/smoothed_feedback_delay.sv
// Top level of the smoothed feedback delay: configuration registers,
// output register, delay-line RAM and the processing core.
// Depends on sfd_pkg, sfd_ram and sfd_core.
//
// Usage:
// Audio samples enter on the slave stream (i_s_tvalid, o_s_tready, i_s_tdata)
// and processed samples leave on the master stream (o_m_tvalid, i_m_tready,
// o_m_tdata), one output transfer for every input transfer, in order.
// Target delay, feedback, mix and the smoothing coefficient are written on
// the configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data), which is always ready; write it only while no sample is in
// flight. Each sample moves the smoothed controls one step toward their
// targets before it is used.
// The core handles one sample at a time on one shared multiplier, so a new
// sample is taken only once the core is through with the last one. The
// result waits in an output register, so the next sample is taken while that
// result is still unclaimed; only the finishing step of that next sample
// waits for the output register to empty, and o_s_tready stays low meanwhile.
// Reset (synchronous, active low) restores the register defaults and the
// smoothed controls, and the delay line reads as silence until each entry is
// first written; there is no clearing pass, so the block is ready at once.
module smoothed_feedback_delay
    import sfd_pkg::*;
#(
    parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TDATA_W-1:0]    i_s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in, rest zero
    // Output stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_W-1:0]    o_m_tdata,   // [SAMPLE_WIDTH-1:0] sample_out, rest zero
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    t_cfg                          r_cfg;
    logic                          r_out_valid;
    logic [SAMPLE_WIDTH-1:0]       r_out_data;

    logic                          res_ready;
    logic                          res_valid;
    logic signed [SAMPLE_WIDTH-1:0] res;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [SAMPLE_WIDTH-1:0]       ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [SAMPLE_WIDTH-1:0]       ram_rdata;

    // Configuration registers; data wider than a register is truncated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_delay    <= TGT_DELAY_W'(TGT_DELAY_RST);
            r_cfg.target_feedback <= TGT_FB_W'(TGT_FB_RST);
            r_cfg.target_mix      <= TGT_MIX_W'(TGT_MIX_RST);
            r_cfg.smoothing_coeff <= COEFF_W'(COEFF_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TARGET_DELAY:    r_cfg.target_delay    <= i_cfg_data[TGT_DELAY_W-1:0];
                REG_TARGET_FEEDBACK: r_cfg.target_feedback <= i_cfg_data[TGT_FB_W-1:0];
                REG_TARGET_MIX:      r_cfg.target_mix      <= i_cfg_data[TGT_MIX_W-1:0];
                REG_SMOOTHING_COEFF: r_cfg.smoothing_coeff <= i_cfg_data[COEFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // The core may finish a sample when the output register is empty or is
    // being emptied in this cycle.
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'(r_out_data);

    sfd_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sfd_core #(
        .STORE_DEPTH  (STORE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_sample    ($signed(i_s_tdata[SAMPLE_WIDTH-1:0])),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule
